FILE: design/fccr_pkg.sv
// ---------------------------------------------------------------------------
// fccr_pkg
// Shared types and constants for the cluster chain reader: beat layouts,
// command kinds, status codes, configuration layout and internal op codes.
// ---------------------------------------------------------------------------
package fccr_pkg;

    localparam int ADDR_W     = 48;
    localparam int CLUSTER_W  = 28;
    localparam int BYTES_W    = 32;
    localparam int SECB_W     = 13;
    localparam int CSEC_W     = 8;
    localparam int LEN_W      = 20;
    localparam int IDX_W      = 10;
    localparam int SEC_W      = 21;
    localparam int PER_SEC_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int DIV_STEPS = CLUSTER_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [CLUSTER_W-1:0] END_MARK          = 28'hFFFFFF7;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 28'd2;
    localparam logic [SECB_W-1:0]    SECB_MIN          = 13'd512;
    localparam logic [SECB_W-1:0]    SECB_MAX          = 13'd4096;
    localparam logic [CSEC_W-1:0]    CSEC_MAX          = 8'd128;

    typedef enum logic [1:0] {
        KIND_COPY = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_REQ  = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OPEN_BYTES = 2'd1,
        ST_IDLE_ENTRY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_REGION   = 3'd0,
        CFG_FAT_OFFSET    = 3'd1,
        CFG_SECTOR_BYTES  = 3'd2,
        CFG_CLUSTER_SECS  = 3'd3,
        CFG_FIRST_CLUSTER = 3'd4,
        CFG_FILE_BYTES    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_NEXT     = 2'd1,
        OP_END      = 2'd2,
        OP_IDLE_ERR = 2'd3
    } t_op_kind;

    typedef struct packed {
        logic        mode;
        logic [31:0] table_entry;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  source_addr;
        logic [LEN_W-1:0]   copy_length;
        logic [BYTES_W-1:0] dest_offset;
        logic [IDX_W-1:0]   entry_index;
        t_status            status;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0]    data_region_offset;
        logic [ADDR_W-1:0]    fat_offset;
        logic [SECB_W-1:0]    sector_bytes;
        logic [CSEC_W-1:0]    cluster_sectors;
        logic [CLUSTER_W-1:0] first_cluster;
        logic [BYTES_W-1:0]   file_bytes;
    } t_cfg;

    typedef struct packed {
        t_op_kind             kind;
        logic [CLUSTER_W-1:0] cluster;
    } t_op;

endpackage

FILE: design/fccr_front.sv
// ---------------------------------------------------------------------------
// fccr_front
// Accepts input beats, tracks whether a walk is open and turns each beat
// into one op for the command queue.
// ---------------------------------------------------------------------------
module fccr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fccr_pkg::t_in  i_in,
    input  logic           i_full,
    output logic           o_push,
    output fccr_pkg::t_op  o_op
);

    logic                           r_walking;
    logic [fccr_pkg::CLUSTER_W-1:0] w_entry;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && o_in_ready;
    assign w_entry    = i_in.table_entry[fccr_pkg::CLUSTER_W-1:0];

    always_comb begin
        o_op.cluster = w_entry;
        if (!i_in.mode) begin
            o_op.kind = fccr_pkg::OP_START;
        end else if (!r_walking) begin
            o_op.kind = fccr_pkg::OP_IDLE_ERR;
        end else if (w_entry >= fccr_pkg::END_MARK) begin
            o_op.kind = fccr_pkg::OP_END;
        end else begin
            o_op.kind = fccr_pkg::OP_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
        end else if (o_push) begin
            if (o_op.kind == fccr_pkg::OP_START) begin
                r_walking <= 1'b1;
            end else if (o_op.kind == fccr_pkg::OP_END) begin
                r_walking <= 1'b0;
            end
        end
    end

endmodule

FILE: design/fccr_queue.sv
// ---------------------------------------------------------------------------
// fccr_queue
// Short op queue between the front and the command engine.
// ---------------------------------------------------------------------------
module fccr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fccr_pkg::t_op  i_op,
    output logic           o_full,
    output logic           o_valid,
    output fccr_pkg::t_op  o_op,
    input  logic           i_pop
);

    fccr_pkg::t_op                r_mem [fccr_pkg::QUEUE_DEPTH];
    logic [fccr_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [fccr_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [fccr_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == fccr_pkg::QCNT_W'(fccr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

FILE: design/fccr_div.sv
// ---------------------------------------------------------------------------
// fccr_div
// Restoring divider, one quotient bit per cycle: cluster number by table
// entries per sector, giving the table sector and the entry index.
// ---------------------------------------------------------------------------
module fccr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fccr_pkg::CLUSTER_W-1:0] i_dividend,
    input  logic [fccr_pkg::PER_SEC_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [fccr_pkg::SEC_W-1:0]     o_quot,
    output logic [fccr_pkg::IDX_W-1:0]     o_rem
);

    logic                            r_busy;
    logic                            r_done;
    logic [fccr_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [fccr_pkg::CLUSTER_W-1:0]  r_acc;
    logic [fccr_pkg::PER_SEC_W-1:0]  r_rem;
    logic [fccr_pkg::PER_SEC_W-1:0]  r_den;
    logic [fccr_pkg::PER_SEC_W:0]    w_shift;
    logic [fccr_pkg::PER_SEC_W+1:0]  w_diff;
    logic                            w_qbit;

    always_comb begin
        w_shift = {r_rem, r_acc[fccr_pkg::CLUSTER_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_den};
        w_qbit  = !w_diff[fccr_pkg::PER_SEC_W+1];
    end

    assign o_done = r_done;
    assign o_quot = r_acc[fccr_pkg::SEC_W-1:0];
    assign o_rem  = r_rem[fccr_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= fccr_pkg::DIV_CNT_W'(fccr_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[fccr_pkg::CLUSTER_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[fccr_pkg::PER_SEC_W-1:0]
                            : w_shift[fccr_pkg::PER_SEC_W-1:0];
        end
    end

endmodule

FILE: design/fccr_back.sv
// ---------------------------------------------------------------------------
// fccr_back
// Command engine: holds the walk state, computes copy and table addresses
// for each cluster and drives the result beats through an output register.
// ---------------------------------------------------------------------------
module fccr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fccr_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  fccr_pkg::t_op  i_q_op,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fccr_pkg::t_out o_out
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_ADDR = 9'b000000100,
        S_COPY = 9'b000001000,
        S_WDIV = 9'b000010000,
        S_FMUL = 9'b000100000,
        S_FAT  = 9'b001000000,
        S_REQ  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic                            r_out_valid;
    fccr_pkg::t_out                  r_out;
    logic                            r_cache_valid;
    logic [fccr_pkg::SEC_W-1:0]      r_cache_sec;
    logic [fccr_pkg::CLUSTER_W-1:0]  r_cluster;
    logic [fccr_pkg::BYTES_W-1:0]    r_bytes_left;
    fccr_pkg::t_status               r_status;
    logic [fccr_pkg::LEN_W-1:0]      r_cbytes;
    logic [fccr_pkg::CLUSTER_W-1:0]  r_rel;
    logic [fccr_pkg::ADDR_W-1:0]     r_src;
    logic [fccr_pkg::LEN_W-1:0]      r_len;
    logic [fccr_pkg::BYTES_W-1:0]    r_dst;
    logic [fccr_pkg::SEC_W-1:0]      r_sec;
    logic [fccr_pkg::IDX_W-1:0]      r_idx;
    logic [fccr_pkg::ADDR_W-1:0]     r_fsrc;

    logic [fccr_pkg::SECB_W-1:0]     w_sb;
    logic [fccr_pkg::CSEC_W-1:0]     w_cs;
    logic [fccr_pkg::LEN_W:0]        w_cbytes_full;
    logic [fccr_pkg::ADDR_W-1:0]     w_data_prod;
    logic [fccr_pkg::ADDR_W-1:0]     w_fat_prod;
    logic                            w_can_emit;
    logic                            w_hit;
    logic                            w_emit;
    fccr_pkg::t_out                  w_out;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [fccr_pkg::SEC_W-1:0]      w_quot;
    logic [fccr_pkg::IDX_W-1:0]      w_rem;

    // Out-of-range geometry registers are clamped to their legal ranges.
    always_comb begin
        if (i_cfg.sector_bytes < fccr_pkg::SECB_MIN) begin
            w_sb = fccr_pkg::SECB_MIN;
        end else if (i_cfg.sector_bytes > fccr_pkg::SECB_MAX) begin
            w_sb = fccr_pkg::SECB_MAX;
        end else begin
            w_sb = i_cfg.sector_bytes;
        end
        if (i_cfg.cluster_sectors == '0) begin
            w_cs = fccr_pkg::CSEC_W'(1);
        end else if (i_cfg.cluster_sectors > fccr_pkg::CSEC_MAX) begin
            w_cs = fccr_pkg::CSEC_MAX;
        end else begin
            w_cs = i_cfg.cluster_sectors;
        end
        w_cbytes_full = {8'd0, w_sb} * {13'd0, w_cs};
        w_data_prod   = {20'd0, r_rel} * {28'd0, r_cbytes};
        w_fat_prod    = {27'd0, r_sec} * {35'd0, w_sb};
    end

    assign w_can_emit = !r_out_valid || i_out_ready;
    assign w_hit      = r_cache_valid && (r_cache_sec == r_sec);

    fccr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_cluster),
        .i_divisor  (w_sb[fccr_pkg::SECB_W-1:2]),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        w_emit      = 1'b0;
        w_out       = '0;
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_op.kind == fccr_pkg::OP_START ||
                        i_q_op.kind == fccr_pkg::OP_NEXT) begin
                        n_state = S_PREP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PREP: begin
                w_div_start = 1'b1;
                n_state     = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                w_out.kind        = fccr_pkg::KIND_COPY;
                w_out.source_addr = r_src;
                w_out.copy_length = r_len;
                w_out.dest_offset = r_dst;
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                if (w_div_done) begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                n_state = S_FAT;
            end
            S_FAT: begin
                w_out.kind        = fccr_pkg::KIND_LOAD;
                w_out.source_addr = r_fsrc;
                w_out.copy_length = {7'd0, w_sb};
                if (w_hit) begin
                    n_state = S_REQ;
                end else if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_REQ;
                end
            end
            S_REQ: begin
                w_out.kind        = fccr_pkg::KIND_REQ;
                w_out.entry_index = r_idx;
                w_out.last        = 1'b1;
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                w_out.kind   = fccr_pkg::KIND_DONE;
                w_out.status = r_status;
                w_out.last   = 1'b1;
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_cache_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop && i_q_op.kind == fccr_pkg::OP_START) begin
                r_cache_valid <= 1'b0;
            end else if (r_state == S_FAT && w_emit) begin
                r_cache_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_q_op.kind)
                fccr_pkg::OP_START: begin
                    r_cluster    <= i_cfg.first_cluster;
                    r_bytes_left <= i_cfg.file_bytes;
                end
                fccr_pkg::OP_NEXT: begin
                    r_cluster <= i_q_op.cluster;
                end
                fccr_pkg::OP_END: begin
                    r_status <= (r_bytes_left != '0) ? fccr_pkg::ST_OPEN_BYTES
                                                     : fccr_pkg::ST_OK;
                end
                default: begin
                    r_status <= fccr_pkg::ST_IDLE_ENTRY;
                end
            endcase
        end
        if (r_state == S_PREP) begin
            r_cbytes <= w_cbytes_full[fccr_pkg::LEN_W-1:0];
            r_rel    <= r_cluster - fccr_pkg::FIRST_DATA_CLUSTER;
        end
        if (r_state == S_ADDR) begin
            r_src <= i_cfg.data_region_offset + w_data_prod;
            r_len <= ({12'd0, r_cbytes} < r_bytes_left) ? r_cbytes
                                                        : r_bytes_left[fccr_pkg::LEN_W-1:0];
            r_dst <= i_cfg.file_bytes - r_bytes_left;
        end
        if (r_state == S_COPY && w_emit) begin
            r_bytes_left <= r_bytes_left - {12'd0, r_len};
        end
        if (r_state == S_WDIV && w_div_done) begin
            r_sec <= w_quot;
            r_idx <= w_rem;
        end
        if (r_state == S_FMUL) begin
            r_fsrc <= i_cfg.fat_offset + w_fat_prod;
        end
        if (r_state == S_FAT && w_emit) begin
            r_cache_sec <= r_sec;
        end
        if (w_emit) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/fat32_cluster_chain_reader.sv
// ---------------------------------------------------------------------------
// fat32_cluster_chain_reader
// Walks one file's allocation table chain and issues data copy, table
// sector load and entry request commands for each cluster.
// ---------------------------------------------------------------------------
// A cluster visit steps through the prep, address, copy, divider wait,
// table multiply, table load and request states, waiting in the middle
// on the 28-step cluster divider in fccr_div; a done beat needs only the
// done state. Up to two further input beats are taken during a visit.
// Reset is synchronous and active low; it clears the control state and
// loads the configuration registers with their defaults.
module fat32_cluster_chain_reader (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fccr_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fccr_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [fccr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fccr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fccr_pkg::t_cfg r_cfg;
    logic           w_push;
    fccr_pkg::t_op  w_push_op;
    logic           w_full;
    logic           w_q_valid;
    fccr_pkg::t_op  w_q_op;
    logic           w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_region_offset <= '0;
            r_cfg.fat_offset         <= '0;
            r_cfg.sector_bytes       <= fccr_pkg::SECB_MIN;
            r_cfg.cluster_sectors    <= fccr_pkg::CSEC_W'(1);
            r_cfg.first_cluster      <= fccr_pkg::FIRST_DATA_CLUSTER;
            r_cfg.file_bytes         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fccr_pkg::CFG_DATA_REGION: begin
                    r_cfg.data_region_offset <= i_cfg_data[fccr_pkg::ADDR_W-1:0];
                end
                fccr_pkg::CFG_FAT_OFFSET: begin
                    r_cfg.fat_offset <= i_cfg_data[fccr_pkg::ADDR_W-1:0];
                end
                fccr_pkg::CFG_SECTOR_BYTES: begin
                    r_cfg.sector_bytes <= i_cfg_data[fccr_pkg::SECB_W-1:0];
                end
                fccr_pkg::CFG_CLUSTER_SECS: begin
                    r_cfg.cluster_sectors <= i_cfg_data[fccr_pkg::CSEC_W-1:0];
                end
                fccr_pkg::CFG_FIRST_CLUSTER: begin
                    r_cfg.first_cluster <= i_cfg_data[fccr_pkg::CLUSTER_W-1:0];
                end
                fccr_pkg::CFG_FILE_BYTES: begin
                    r_cfg.file_bytes <= i_cfg_data[fccr_pkg::BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    fccr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    fccr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_pop)
    );

    fccr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

FILE: verif/fat32_chain_checker.sv
// ---------------------------------------------------------------------------
// fat32_chain_checker
// Watches the input, output and register write ports of the cluster chain
// reader. Keeps its own copy of the registers and walk state, predicts the
// command beats of each accepted input beat and compares every accepted
// output beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module fat32_chain_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  fccr_pkg::t_in                   i_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  fccr_pkg::t_out                  i_out,
    input  logic                            i_cfg_we,
    input  logic [fccr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fccr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_beats_checked
);
    import fccr_pkg::*;

    localparam logic [27:0] CHAIN_END  = 28'hFFFFFF7;
    localparam logic [27:0] FIRST_DATA = 28'd2;

    t_cfg        regs;
    logic [27:0] cur_cluster;
    logic [31:0] bytes_remaining;
    logic [31:0] fat_sec_cached;
    logic        in_walk;
    t_out        cmd_queue[$];
    t_out        oldest;
    int          errors = 0;
    int          beats_seen = 0;

    // Copy, optional table sector load and entry request for cur_cluster.
    function automatic void queue_cluster_cmds();
        logic [63:0] sec_bytes;
        logic [63:0] clu_bytes;
        logic [63:0] copy_len;
        logic [63:0] per_sec;
        logic [63:0] fat_sec;
        logic [63:0] entry_idx;
        logic [63:0] addr;
        logic [27:0] rel_cluster;
        t_out        cmd;
        sec_bytes = regs.sector_bytes;
        if (sec_bytes < 512) sec_bytes = 512;
        else if (sec_bytes > 4096) sec_bytes = 4096;
        clu_bytes = regs.cluster_sectors;
        if (clu_bytes == 0) clu_bytes = 1;
        else if (clu_bytes > 128) clu_bytes = 128;
        clu_bytes = clu_bytes * sec_bytes;
        copy_len = bytes_remaining;
        if (clu_bytes < copy_len) copy_len = clu_bytes;
        // Clusters below two wrap within the 28-bit cluster space.
        rel_cluster = cur_cluster - FIRST_DATA;
        addr = regs.data_region_offset + rel_cluster * clu_bytes;
        cmd = '0;
        cmd.kind = KIND_COPY;
        cmd.source_addr = addr[47:0];
        cmd.copy_length = copy_len[19:0];
        cmd.dest_offset = regs.file_bytes - bytes_remaining;
        cmd_queue.push_back(cmd);
        bytes_remaining = bytes_remaining - copy_len[31:0];

        per_sec = sec_bytes >> 2;
        fat_sec = cur_cluster / per_sec;
        entry_idx = cur_cluster % per_sec;
        if (fat_sec[31:0] != fat_sec_cached) begin
            addr = regs.fat_offset + fat_sec * sec_bytes;
            cmd = '0;
            cmd.kind = KIND_LOAD;
            cmd.source_addr = addr[47:0];
            cmd.copy_length = sec_bytes[19:0];
            cmd_queue.push_back(cmd);
            fat_sec_cached = fat_sec[31:0];
        end
        cmd = '0;
        cmd.kind = KIND_REQ;
        cmd.entry_index = entry_idx[9:0];
        cmd.last = 1'b1;
        cmd_queue.push_back(cmd);
    endfunction

    function automatic void queue_done(input t_status st);
        t_out cmd;
        cmd = '0;
        cmd.kind = KIND_DONE;
        cmd.status = st;
        cmd.last = 1'b1;
        cmd_queue.push_back(cmd);
    endfunction

    function automatic void take_in_beat(input t_in beat);
        logic [27:0] entry;
        entry = beat.table_entry[27:0];
        // Mode low starts a walk; mode high returns a table entry.
        if (!beat.mode) begin
            cur_cluster = regs.first_cluster;
            bytes_remaining = regs.file_bytes;
            fat_sec_cached = '1;
            in_walk = 1'b1;
            queue_cluster_cmds();
        end else if (!in_walk) begin
            queue_done(ST_IDLE_ENTRY);
        end else if (entry >= CHAIN_END) begin
            in_walk = 1'b0;
            if (bytes_remaining != 0) queue_done(ST_OPEN_BYTES);
            else queue_done(ST_OK);
        end else begin
            cur_cluster = entry;
            queue_cluster_cmds();
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.data_region_offset = '0;
            regs.fat_offset = '0;
            regs.sector_bytes = 13'd512;
            regs.cluster_sectors = 8'd1;
            regs.first_cluster = 28'd2;
            regs.file_bytes = '0;
            cur_cluster = '0;
            bytes_remaining = '0;
            fat_sec_cached = '1;
            in_walk = 1'b0;
            cmd_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                beats_seen++;
                if (cmd_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, i_out);
                end else begin
                    oldest = cmd_queue.pop_front();
                    check_field("kind", oldest.kind, i_out.kind);
                    check_field("source_addr", oldest.source_addr, i_out.source_addr);
                    check_field("copy_length", oldest.copy_length, i_out.copy_length);
                    check_field("dest_offset", oldest.dest_offset, i_out.dest_offset);
                    check_field("entry_index", oldest.entry_index, i_out.entry_index);
                    check_field("status", oldest.status, i_out.status);
                    check_field("last", oldest.last, i_out.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DATA_REGION:   regs.data_region_offset = i_cfg_data[47:0];
                    CFG_FAT_OFFSET:    regs.fat_offset = i_cfg_data[47:0];
                    CFG_SECTOR_BYTES:  regs.sector_bytes = i_cfg_data[12:0];
                    CFG_CLUSTER_SECS:  regs.cluster_sectors = i_cfg_data[7:0];
                    CFG_FIRST_CLUSTER: regs.first_cluster = i_cfg_data[27:0];
                    CFG_FILE_BYTES:    regs.file_bytes = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_in_beat(i_in);
        end
        o_fail_count <= errors;
        o_pending <= cmd_queue.size();
        o_beats_checked <= beats_seen;
    end

endmodule

FILE: verif/fat32_cluster_chain_reader_tb.sv
// ---------------------------------------------------------------------------
// fat32_cluster_chain_reader_tb
// Drives start and table entry beats into the cluster chain reader under a
// series of register settings, with random gaps on the input and random
// back-pressure on the output. A separate checker predicts and compares
// every command beat; this module makes the stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module fat32_cluster_chain_reader_tb;
    import fccr_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 9;
    localparam int          IDLE_PCT      = 36;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 54;
    localparam int          QUIET_PHASE   = 3;
    localparam logic        MODE_START    = 1'b0;
    localparam logic        MODE_ENTRY    = 1'b1;
    localparam logic [27:0] CHAIN_END     = 28'hFFFFFF7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_beat;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  quiet = 1'b0;
    int                    fail_count;
    int                    pending;
    int                    beats_checked;
    int                    beats_sent = 0;
    int                    settings = 1;
    int                    cycle_count;
    t_cfg                  cur_cfg;
    logic [27:0]           last_cluster;

    fat32_cluster_chain_reader uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    fat32_chain_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in            (in_beat),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out           (out_beat),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Valid is only lowered when a gap is taken, so back-to-back beats keep
    // it high without a second assignment in the same step.
    task automatic send_beat(input logic mode, input logic [31:0] entry);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_beat <= {mode, entry};
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_entry(input logic [27:0] cluster);
        logic [31:0] r;
        r = $urandom;
        send_beat(MODE_ENTRY, {r[31:28], cluster});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_DATA_REGION, c.data_region_offset);
        write_reg(CFG_FAT_OFFSET, c.fat_offset);
        write_reg(CFG_SECTOR_BYTES, {35'd0, c.sector_bytes});
        write_reg(CFG_CLUSTER_SECS, {40'd0, c.cluster_sectors});
        write_reg(CFG_FIRST_CLUSTER, {20'd0, c.first_cluster});
        write_reg(CFG_FILE_BYTES, {16'd0, c.file_bytes});
        cfg_we <= 1'b0;
        cur_cfg = c;
        settings++;
    endtask

    // Mostly small sectors and clusters and short files, so that chains end
    // both exactly on the file size and with bytes still left.
    function automatic t_cfg random_config();
        t_cfg        c;
        logic [63:0] wide;
        logic [31:0] r;
        wide = {$urandom, $urandom};
        c.data_region_offset = wide[47:0];
        wide = {$urandom, $urandom};
        c.fat_offset = wide[47:0];
        r = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: c.sector_bytes = 13'd512;
            6: c.sector_bytes = 13'd4096;
            7: c.sector_bytes = r[0] ? 13'd1024 : 13'd2048;
            8: c.sector_bytes = r[12:0];
            default: begin
                r = $urandom_range(4096, 512);
                c.sector_bytes = r[12:0];
            end
        endcase
        r = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                r = $urandom_range(4, 1);
                c.cluster_sectors = r[7:0];
            end
            6: c.cluster_sectors = 8'd0;
            7: c.cluster_sectors = 8'd128;
            8: c.cluster_sectors = r[7:0];
            default: begin
                r = $urandom_range(128, 1);
                c.cluster_sectors = r[7:0];
            end
        endcase
        r = $urandom;
        if (r[0]) r = $urandom_range(3000);
        c.first_cluster = r[27:0];
        if ($urandom_range(9) < 9) r = $urandom_range(20000);
        else r = $urandom;
        c.file_bytes = r;
        return c;
    endfunction

    // A start, a few hops along the chain and usually an end mark, now and
    // then followed by a stray entry that lands while the block is idle.
    task automatic random_walk();
        int          hops;
        logic [31:0] r;
        logic [27:0] nxt;
        hops = $urandom_range(6);
        send_beat(MODE_START, $urandom);
        last_cluster = cur_cfg.first_cluster;
        repeat (hops) begin
            case ($urandom_range(9))
                0, 1, 2, 3: nxt = last_cluster + 28'd1;
                4, 5, 6: begin
                    r = $urandom_range(4999);
                    nxt = r[27:0];
                end
                default: begin
                    r = $urandom;
                    nxt = r[27:0];
                end
            endcase
            send_entry(nxt);
            last_cluster = nxt;
        end
        if ($urandom_range(9) < 8) begin
            r = $urandom_range(8);
            send_entry(CHAIN_END + r[27:0]);
            if ($urandom_range(3) == 0) begin
                r = $urandom;
                send_entry(r[27:0]);
            end
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        int   stop_at;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: entries while idle, a walk with a restart in
        // the middle, and the end mark hidden behind set upper bits.
        cur_cfg = {48'd0, 48'd0, 13'd512, 8'd1, 28'd2, 32'd0};
        send_beat(MODE_ENTRY, 32'h00000000);
        send_beat(MODE_ENTRY, 32'hFFFFFFFF);
        send_beat(MODE_START, 32'hFFFFFFFF);
        send_beat(MODE_ENTRY, 32'h00000003);
        send_beat(MODE_ENTRY, 32'hF0000200);
        send_beat(MODE_ENTRY, 32'h0FFFFFF6);
        send_beat(MODE_START, 32'h00000000);
        send_beat(MODE_ENTRY, 32'h0FFFFFF7);
        send_beat(MODE_ENTRY, 32'h1FFFFFF7);
        drain();

        // Oversized sector, zero cluster sectors, first cluster below two,
        // largest file and offsets at the top of the address space.
        c = {48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 8'd0, 28'd0, 32'hFFFFFFFF};
        load_config(c);
        send_beat(MODE_START, 32'h12345678);
        send_beat(MODE_ENTRY, 32'h00000001);
        send_beat(MODE_ENTRY, 32'hA0000000);
        send_beat(MODE_ENTRY, 32'hFFFFFFF8);
        send_beat(MODE_START, 32'h00000000);
        send_beat(MODE_ENTRY, 32'hFFFFFFFF);
        drain();

        // Undersized sector, cluster sectors above the cap, top cluster.
        c = {48'h0000_0000_1000, 48'h0000_0000_0200, 13'd100, 8'd255, 28'hFFFFFFF, 32'd5000};
        load_config(c);
        send_beat(MODE_START, 32'h00000000);
        send_beat(MODE_ENTRY, 32'h00000007);
        send_beat(MODE_ENTRY, 32'h7FFFFFFC);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                c = {48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 13'd4096, 8'd128,
                     28'hFFFFFF6, 32'hFFFFFFFF};
            end else begin
                c = random_config();
            end
            load_config(c);
            quiet = (ph == QUIET_PHASE);
            stop_at = beats_sent + PHASE_ITEMS;
            while (beats_sent < stop_at) random_walk();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input beats under %0d register settings; %0d command beats compared.",
                 beats_sent, settings, beats_checked);
        $display("Covered idle entries, restarts mid-walk, chain ends with and without bytes left,");
        $display("out-of-range sector and cluster sizes, and address wrap.");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
        $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: fat32_cluster_chain_reader.f
design/fccr_pkg.sv
design/fccr_front.sv
design/fccr_queue.sv
design/fccr_div.sv
design/fccr_back.sv
design/fat32_cluster_chain_reader.sv
verif/fat32_chain_checker.sv
verif/fat32_cluster_chain_reader_tb.sv
